@@ rtl/lwp_pkg.sv @@
// Shared types and constants for the LCD window RGB444 pixel packer.
package lwp_pkg;

    localparam logic [1:0] OP_OPEN  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    localparam logic [2:0] CFG_COL_OFS   = 3'd0;
    localparam logic [2:0] CFG_ROW_OFS   = 3'd1;
    localparam logic [2:0] CFG_BROKEN    = 3'd2;
    localparam logic [2:0] CFG_COL_CMD   = 3'd3;
    localparam logic [2:0] CFG_PAGE_CMD  = 3'd4;
    localparam logic [2:0] CFG_MEMWR_CMD = 3'd5;
    localparam logic [2:0] CFG_NOOP_CMD  = 3'd6;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    localparam logic [2:0] LAST_OPEN = 3'd6;
    localparam logic [2:0] LAST_PKT  = 3'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  win_col;
        logic [7:0]  win_row;
        logic [7:0]  win_width;
        logic [7:0]  win_height;
        logic [11:0] pixel_color;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_command;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic [7:0] ram_col_offset;
        logic [7:0] ram_row_offset;
        logic       broken_mode;
        logic [7:0] col_cmd_code;
        logic [7:0] page_cmd_code;
        logic [7:0] memwrite_cmd_code;
        logic [7:0] noop_cmd_code;
    } t_cfg;

    typedef enum logic [1:0] {
        JOB_OPEN,
        JOB_PAIR,
        JOB_LONE
    } t_job_kind;

    // open: d0/d1 column range, d2/d3 page range; pair: d0..d2; lone: d0, d1
    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] d3;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_job_push;

endpackage

@@ rtl/lwp_front.sv @@
// Front end: accepts items, tracks pixel pairing and builds byte jobs.
module lwp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lwp_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    input  lwp_pkg::t_in_word i_in_word,
    input  logic              i_q_full,
    output logic              o_in_stall,
    output lwp_pkg::t_job_push o_push
);
    import lwp_pkg::*;

    logic [11:0] r_held, n_held;
    logic [11:0] r_first, n_first;
    logic        r_odd, n_odd;
    logic        r_first_seen, n_first_seen;
    logic        accept;
    logic        job_valid;
    t_job        job;
    logic [7:0]  c0, r0;
    logic [11:0] pair_b;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign c0 = 8'(i_cfg.ram_col_offset + i_in_word.win_col);
    assign r0 = 8'(i_cfg.ram_row_offset + i_in_word.win_row);
    assign pair_b = (i_in_word.op == OP_PIXEL) ? i_in_word.pixel_color : r_first;

    always_comb begin
        job_valid    = 1'b0;
        job.kind     = JOB_PAIR;
        job.d0       = r_held[11:4];
        job.d1       = {r_held[3:0], pair_b[11:8]};
        job.d2       = pair_b[7:0];
        job.d3       = 8'd0;
        n_held       = r_held;
        n_first      = r_first;
        n_odd        = r_odd;
        n_first_seen = r_first_seen;
        case (i_in_word.op)
            OP_OPEN: begin
                job_valid    = 1'b1;
                job.kind     = JOB_OPEN;
                job.d0       = c0;
                job.d1       = 8'(c0 + i_in_word.win_width - 8'd1);
                job.d2       = r0;
                job.d3       = 8'(r0 + i_in_word.win_height - 8'd1);
                n_odd        = 1'b0;
                n_first_seen = 1'b0;
            end
            OP_PIXEL: begin
                if (!r_first_seen) begin
                    n_first      = i_in_word.pixel_color;
                    n_first_seen = 1'b1;
                end
                if (r_odd) begin
                    job_valid = 1'b1;
                    n_odd     = 1'b0;
                end else begin
                    n_held = i_in_word.pixel_color;
                    n_odd  = 1'b1;
                end
            end
            OP_STOP: begin
                if (r_odd) begin
                    job_valid = 1'b1;
                    n_odd     = 1'b0;
                    if (!i_cfg.broken_mode) begin
                        job.kind = JOB_LONE;
                        job.d1   = {r_held[3:0], 4'h0};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_push.push = accept && job_valid;
    assign o_push.job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_first      <= '0;
            r_odd        <= 1'b0;
            r_first_seen <= 1'b0;
        end else if (accept) begin
            r_held       <= n_held;
            r_first      <= n_first;
            r_odd        <= n_odd;
            r_first_seen <= n_first_seen;
        end
    end

    a_pair_clears_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_word.op == OP_PIXEL && r_odd |-> o_push.push)
        else $error("paired pixel produced no job");

endmodule

@@ rtl/lwp_fifo.sv @@
// Two-entry job queue between front end and byte sequencer.
module lwp_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lwp_pkg::t_job_push i_push,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output lwp_pkg::t_job      o_head
);
    import lwp_pkg::*;

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, r_rd;
    logic [Q_AW:0]     r_count, n_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push.push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

@@ rtl/lwp_back.sv @@
// Back end: walks the head job byte by byte into the output register.
module lwp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lwp_pkg::t_cfg      i_cfg,
    input  logic               i_empty,
    input  lwp_pkg::t_job      i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    output lwp_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);
    import lwp_pkg::*;

    logic [2:0] r_idx, n_idx;
    logic       r_out_valid;
    t_out_word  r_out_word, n_out_word;
    logic       load;
    logic [2:0] last_idx;

    assign last_idx = (i_head.kind == JOB_OPEN) ? LAST_OPEN : LAST_PKT;
    assign load     = !i_empty && (!r_out_valid || !i_out_stall);
    assign o_pop    = load && (r_idx == last_idx);
    assign n_idx    = o_pop ? 3'd0 : 3'(r_idx + 3'd1);

    always_comb begin
        n_out_word.out_byte   = i_head.d0;
        n_out_word.is_command = 1'b0;
        n_out_word.last       = (r_idx == last_idx);
        case (i_head.kind)
            JOB_OPEN: begin
                case (r_idx)
                    3'd0: begin
                        n_out_word.out_byte   = i_cfg.col_cmd_code;
                        n_out_word.is_command = 1'b1;
                    end
                    3'd1: n_out_word.out_byte = i_head.d0;
                    3'd2: n_out_word.out_byte = i_head.d1;
                    3'd3: begin
                        n_out_word.out_byte   = i_cfg.page_cmd_code;
                        n_out_word.is_command = 1'b1;
                    end
                    3'd4: n_out_word.out_byte = i_head.d2;
                    3'd5: n_out_word.out_byte = i_head.d3;
                    default: begin
                        n_out_word.out_byte   = i_cfg.memwrite_cmd_code;
                        n_out_word.is_command = 1'b1;
                    end
                endcase
            end
            JOB_LONE: begin
                case (r_idx)
                    3'd0: n_out_word.out_byte = i_head.d0;
                    3'd1: n_out_word.out_byte = i_head.d1;
                    default: begin
                        n_out_word.out_byte   = i_cfg.noop_cmd_code;
                        n_out_word.is_command = 1'b1;
                    end
                endcase
            end
            default: begin
                case (r_idx)
                    3'd0: n_out_word.out_byte = i_head.d0;
                    3'd1: n_out_word.out_byte = i_head.d1;
                    default: n_out_word.out_byte = i_head.d2;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_word <= n_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= n_idx;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> r_idx <= last_idx)
        else $error("byte index past end of job");

    a_idle_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> r_idx == 3'd0)
        else $error("byte index left mid-job with empty queue");

endmodule

@@ rtl/lcd_window_rgb444_pixel_packer.sv @@
// Top level of the LCD window RGB444 pixel packer: config registers and datapath.
// Turns open/pixel/stop words into the controller's command and data byte stream,
// one byte per cycle on the output while jobs are queued and the output is not
// stalled. A decoder takes one input word per cycle whenever the two-entry job
// queue has room; words that cause no bytes (a lone pixel, a stop with nothing
// held, the unused op code) go straight through. The byte sequencer at the
// queue head sets the sustained rate: an open costs 7 bytes, a pixel pair 3, a
// stop flush 3; pixels average 1.5 bytes each. The job queue buffers output stalls.
module lcd_window_rgb444_pixel_packer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lwp_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lwp_pkg::t_out_word o_out_word
);
    import lwp_pkg::*;

    t_cfg      r_cfg;
    t_job_push push;
    t_job      head;
    logic      q_full;
    logic      q_empty;
    logic      pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ram_col_offset    <= 8'd0;
            r_cfg.ram_row_offset    <= 8'd2;
            r_cfg.broken_mode       <= 1'b1;
            r_cfg.col_cmd_code      <= 8'd21;
            r_cfg.page_cmd_code     <= 8'd117;
            r_cfg.memwrite_cmd_code <= 8'd92;
            r_cfg.noop_cmd_code     <= 8'd37;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COL_OFS:   r_cfg.ram_col_offset    <= i_cfg_data;
                CFG_ROW_OFS:   r_cfg.ram_row_offset    <= i_cfg_data;
                CFG_BROKEN:    r_cfg.broken_mode       <= i_cfg_data[0];
                CFG_COL_CMD:   r_cfg.col_cmd_code      <= i_cfg_data;
                CFG_PAGE_CMD:  r_cfg.page_cmd_code     <= i_cfg_data;
                CFG_MEMWR_CMD: r_cfg.memwrite_cmd_code <= i_cfg_data;
                CFG_NOOP_CMD:  r_cfg.noop_cmd_code     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lwp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push)
    );

    lwp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    lwp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ tb/lcd_window_rgb444_pixel_packer_tb.sv @@
// Testbench for the LCD window RGB444 pixel packer: directed table, then random windows.
module lcd_window_rgb444_pixel_packer_tb;
    import lwp_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int DRAIN     = 16;
    localparam int QUIET_MAX = 1000;

    typedef struct {
        logic            is_cfg;
        logic [2:0]      reg_idx;
        logic [7:0]      reg_val;
        t_in_word        w;
        int              n_typed;   // -1: bytes come from encode_word
        logic [0:6][7:0] b;
        logic [0:6]      cmd;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;

    // shadow registers and packer state
    t_cfg        regs;
    logic [11:0] held_px;
    logic [11:0] first_px;
    logic        px_odd;
    logic        first_px_valid;

    t_out_word enc_bytes[$];
    t_out_word lcd_bytes_due[$];

    bit calm = 1'b0;
    int errors = 0;
    int quiet = 0;
    int n_open = 0, n_pixel = 0, n_stop = 0, n_unused = 0, n_bytes = 0, n_cfg = 0;

    lcd_window_rgb444_pixel_packer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 34);
    end

    function automatic void emit(input logic [7:0] b, input logic cmd);
        lcd_bytes_due.push_back(t_out_word'(0));
        void'(lcd_bytes_due.pop_back());
        enc_bytes.push_back('{out_byte: b, is_command: cmd, last: 1'b0});
    endfunction

    function automatic void emit_pair(input logic [11:0] a, input logic [11:0] b);
        emit(a[11:4], 1'b0);
        emit({a[3:0], b[11:8]}, 1'b0);
        emit(b[7:0], 1'b0);
    endfunction

    function automatic void encode_word(input t_in_word w);
        logic [7:0] c0;
        logic [7:0] r0;
        enc_bytes.delete();
        case (w.op)
            OP_OPEN: begin
                c0 = regs.ram_col_offset + w.win_col;
                r0 = regs.ram_row_offset + w.win_row;
                emit(regs.col_cmd_code, 1'b1);
                emit(c0, 1'b0);
                emit(c0 + w.win_width - 8'd1, 1'b0);
                emit(regs.page_cmd_code, 1'b1);
                emit(r0, 1'b0);
                emit(r0 + w.win_height - 8'd1, 1'b0);
                emit(regs.memwrite_cmd_code, 1'b1);
                px_odd = 1'b0;
                first_px_valid = 1'b0;
            end
            OP_PIXEL: begin
                if (!first_px_valid) begin
                    first_px = w.pixel_color;
                    first_px_valid = 1'b1;
                end
                if (px_odd) begin
                    emit_pair(held_px, w.pixel_color);
                    px_odd = 1'b0;
                end else begin
                    held_px = w.pixel_color;
                    px_odd = 1'b1;
                end
            end
            OP_STOP: begin
                if (px_odd) begin
                    if (regs.broken_mode) begin
                        emit_pair(held_px, first_px);
                    end else begin
                        emit(held_px[11:4], 1'b0);
                        emit({held_px[3:0], 4'h0}, 1'b0);
                        emit(regs.noop_cmd_code, 1'b1);
                    end
                    px_odd = 1'b0;
                end
            end
            default: ;
        endcase
        if (enc_bytes.size() > 0) enc_bytes[enc_bytes.size() - 1].last = 1'b1;
    endfunction

    function automatic t_in_word mk_word(input logic [1:0] op,
                                         input logic [7:0] col, row, wid, hgt,
                                         input logic [11:0] color);
        t_in_word w;
        w.op          = op;
        w.win_col     = col;
        w.win_row     = row;
        w.win_width   = wid;
        w.win_height  = hgt;
        w.pixel_color = color;
        return w;
    endfunction

    function automatic t_in_word rand_word(input logic [1:0] op);
        logic [63:0] r;
        t_in_word w;
        r = {$urandom, $urandom};
        w = r[$bits(t_in_word)-1:0];
        w.op = op;
        if (op == OP_OPEN && $urandom_range(7) != 0) begin
            w.win_col    = 8'($urandom_range(131));
            w.win_row    = 8'($urandom_range(131));
            w.win_width  = 8'($urandom_range(132, 1));
            w.win_height = 8'($urandom_range(132, 1));
        end
        return w;
    endfunction

    function automatic t_row typed_row(input t_in_word w, input int n,
                                       input logic [0:6][7:0] b, input logic [0:6] cmd);
        t_row r;
        r.is_cfg  = 1'b0;
        r.reg_idx = CFG_COL_OFS;
        r.reg_val = 8'h00;
        r.w       = w;
        r.n_typed = n;
        r.b       = b;
        r.cmd     = cmd;
        return r;
    endfunction

    function automatic t_row item_row(input t_in_word w);
        return typed_row(w, -1, '0, '0);
    endfunction

    function automatic t_row cfg_row(input logic [2:0] idx, input logic [7:0] val);
        t_row r;
        r = typed_row('0, -1, '0, '0);
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic push_word(input t_row r);
        int k;
        while (!calm && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= r.w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        case (r.w.op)
            OP_OPEN:  n_open++;
            OP_PIXEL: n_pixel++;
            OP_STOP:  n_stop++;
            default:  n_unused++;
        endcase
        encode_word(r.w);
        if (r.n_typed < 0) begin
            foreach (enc_bytes[i]) lcd_bytes_due.push_back(enc_bytes[i]);
        end else begin
            for (k = 0; k < r.n_typed; k++) begin
                lcd_bytes_due.push_back('{out_byte: r.b[k], is_command: r.cmd[k],
                                          last: (k == r.n_typed - 1)});
            end
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (lcd_bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_cfg++;
        case (idx)
            CFG_COL_OFS:   regs.ram_col_offset    = val;
            CFG_ROW_OFS:   regs.ram_row_offset    = val;
            CFG_BROKEN:    regs.broken_mode       = val[0];
            CFG_COL_CMD:   regs.col_cmd_code      = val;
            CFG_PAGE_CMD:  regs.page_cmd_code     = val;
            CFG_MEMWR_CMD: regs.memwrite_cmd_code = val;
            CFG_NOOP_CMD:  regs.noop_cmd_code     = val;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [7:0] co, ro, bm, cc, pc, mc, nc);
        write_reg(CFG_COL_OFS, co);
        write_reg(CFG_ROW_OFS, ro);
        write_reg(CFG_BROKEN, bm);
        write_reg(CFG_COL_CMD, cc);
        write_reg(CFG_PAGE_CMD, pc);
        write_reg(CFG_MEMWR_CMD, mc);
        write_reg(CFG_NOOP_CMD, nc);
    endtask

    // mostly open / pixels / stop windows, with stray pixels, stops and unused ops
    task automatic run_phase(input int n_items);
        int sent;
        int npix;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                push_word(item_row(rand_word(OP_OPEN)));
                npix = $urandom_range(9);
                repeat (npix) push_word(item_row(rand_word(OP_PIXEL)));
                push_word(item_row(rand_word(OP_STOP)));
                sent += npix + 2;
                if ($urandom_range(9) == 0) begin
                    push_word(item_row(rand_word(OP_STOP)));
                    sent++;
                end
            end else if (pick < 88) begin
                push_word(item_row(rand_word(OP_PIXEL)));
                sent++;
            end else if (pick < 95) begin
                push_word(item_row(rand_word(OP_STOP)));
                sent++;
            end else begin
                push_word(item_row(rand_word(OP_UNUSED)));
            end
        end
    endtask

    always @(posedge i_clk) begin : chk_out
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_bytes++;
            if (lcd_bytes_due.size() == 0) begin
                $display("%0t: unexpected word byte=%02h cmd=%0b last=%0b", $time,
                         o_out_word.out_byte, o_out_word.is_command, o_out_word.last);
                errors++;
            end else begin
                want = lcd_bytes_due.pop_front();
                if (want.out_byte !== o_out_word.out_byte ||
                    want.is_command !== o_out_word.is_command ||
                    want.last !== o_out_word.last) begin
                    $display({"%0t: mismatch exp byte=%02h cmd=%0b last=%0b",
                              " got byte=%02h cmd=%0b last=%0b"},
                             $time, want.out_byte, want.is_command, want.last,
                             o_out_word.out_byte, o_out_word.is_command, o_out_word.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= QUIET_MAX) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_MAX);
            $display("FAIL lcd_window_rgb444_pixel_packer");
            $finish;
        end
    end

    initial begin
        t_row plan[$];
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_COL_OFS;
        i_cfg_data <= 8'h00;
        i_in_valid <= 1'b0;
        i_in_word  <= '0;

        regs.ram_col_offset    = 8'd0;
        regs.ram_row_offset    = 8'd2;
        regs.broken_mode       = 1'b1;
        regs.col_cmd_code      = 8'd21;
        regs.page_cmd_code     = 8'd117;
        regs.memwrite_cmd_code = 8'd92;
        regs.noop_cmd_code     = 8'd37;
        held_px        = '0;
        first_px       = '0;
        px_odd         = 1'b0;
        first_px_valid = 1'b0;

        // reset config: col offset 0, row offset 2, broken mode on
        plan.push_back(typed_row(mk_word(OP_STOP, 0, 0, 0, 0, 0), 0, '0, '0));
        plan.push_back(typed_row(mk_word(OP_PIXEL, 0, 0, 0, 0, 12'hABC), 0, '0, '0));
        plan.push_back(typed_row(mk_word(OP_PIXEL, 0, 0, 0, 0, 12'h123), 3,
                                 {8'hAB, 8'hC1, 8'h23, 32'h0}, 7'b0000000));
        plan.push_back(typed_row(mk_word(OP_OPEN, 0, 0, 1, 1, 0), 7,
                                 {8'h15, 8'h00, 8'h00, 8'h75, 8'h02, 8'h02, 8'h5C},
                                 7'b1001001));
        // end addresses wrap past 255
        plan.push_back(typed_row(mk_word(OP_OPEN, 131, 131, 132, 132, 0), 7,
                                 {8'h15, 8'h83, 8'h06, 8'h75, 8'h85, 8'h08, 8'h5C},
                                 7'b1001001));
        plan.push_back(item_row(mk_word(OP_OPEN, 5, 7, 0, 0, 12'hFFF)));
        plan.push_back(item_row(mk_word(OP_OPEN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'hFFF)));
        plan.push_back(typed_row(mk_word(OP_PIXEL, 0, 0, 0, 0, 12'hFFF), 0, '0, '0));
        plan.push_back(typed_row(mk_word(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'h000), 3,
                                 {8'hFF, 8'hF0, 8'h00, 32'h0}, 7'b0000000));
        plan.push_back(typed_row(mk_word(OP_PIXEL, 0, 0, 0, 0, 12'h5A5), 0, '0, '0));
        plan.push_back(item_row(mk_word(OP_STOP, 0, 0, 0, 0, 0)));
        plan.push_back(typed_row(mk_word(OP_STOP, 0, 0, 0, 0, 0), 0, '0, '0));
        plan.push_back(typed_row(mk_word(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'hFFF),
                                 0, '0, '0));
        plan.push_back(typed_row(mk_word(OP_PIXEL, 0, 0, 0, 0, 12'h000), 0, '0, '0));
        plan.push_back(item_row(mk_word(OP_STOP, 0, 0, 0, 0, 0)));
        plan.push_back(cfg_row(CFG_BROKEN, 8'h00));
        plan.push_back(typed_row(mk_word(OP_PIXEL, 0, 0, 0, 0, 12'h9C3), 0, '0, '0));
        plan.push_back(typed_row(mk_word(OP_STOP, 0, 0, 0, 0, 0), 3,
                                 {8'h9C, 8'h30, 8'h25, 32'h0}, 7'b0010000));
        plan.push_back(typed_row(mk_word(OP_PIXEL, 0, 0, 0, 0, 12'h111), 0, '0, '0));
        plan.push_back(item_row(mk_word(OP_OPEN, 10, 20, 3, 4, 0)));
        plan.push_back(typed_row(mk_word(OP_STOP, 0, 0, 0, 0, 0), 0, '0, '0));
        plan.push_back(item_row(mk_word(OP_PIXEL, 0, 0, 0, 0, 12'h777)));
        plan.push_back(item_row(mk_word(OP_STOP, 0, 0, 0, 0, 0)));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_cfg)
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            else
                push_word(plan[k]);
        end

        load_config(0, 0, 0, 0, 0, 0, 0);
        run_phase(38);
        load_config(131, 131, 8'hFF, 255, 255, 255, 255);
        run_phase(38);
        calm = 1'b1;
        load_config(8'($urandom_range(131)), 8'($urandom_range(131)),
                    8'($urandom_range(1)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
        run_phase(38);
        calm = 1'b0;
        load_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
        run_phase(38);
        write_reg(CFG_UNUSED, 8'($urandom_range(255)));
        load_config(0, 2, 1, 21, 117, 92, 37);
        run_phase(38);
        wait_idle();

        $display("Covered %0d opens, %0d pixels, %0d stops and %0d unused-op words;",
                 n_open, n_pixel, n_stop, n_unused);
        $display("%0d bytes checked, %0d register writes across six settings.",
                 n_bytes, n_cfg);
        if (errors == 0) begin
            $display("PASS lcd_window_rgb444_pixel_packer");
        end else begin
            $display("FAIL lcd_window_rgb444_pixel_packer");
        end
        $finish;
    end

endmodule
